[hw/rtl/ota_packet_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Clocked assertion shorthands used by the deframer top level.
// ----------------------------------------------------------------------------
`ifndef OTA_PACKET_DEFRAMER_ASSERT_SVH
`define OTA_PACKET_DEFRAMER_ASSERT_SVH

// Check on every rising edge, quiet while reset is asserted.
`define OTA_PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check on every rising edge, reset included.
`define OTA_PD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/ota_pd_pkg.sv]
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared types, constants and lookup functions of the packet deframer.
// ----------------------------------------------------------------------------
package ota_pd_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int unsigned PLEN_W       = 10;
  localparam int unsigned TYPE_COUNT   = 9;

  // Raw channel mode codes and the decoder modes they map to
  localparam logic [7:0] MODE_RAW_STD  = 8'h00;
  localparam logic [7:0] MODE_RAW_HQ   = 8'h80;
  localparam logic [7:0] MODE_RAW_A0   = 8'ha0;
  localparam logic [7:0] MODE_RAW_C0   = 8'hc0;
  localparam logic [2:0] DEC_MODE_NONE = 3'd0;
  localparam logic [2:0] DEC_MODE_HQ   = 3'd1;
  localparam logic [2:0] DEC_MODE_STD  = 3'd2;
  localparam logic [2:0] DEC_MODE_A0   = 3'd4;
  localparam logic [2:0] DEC_MODE_C0   = 3'd5;

  typedef enum logic [2:0] {
    KIND_HDR_BYTE = 3'd0,
    KIND_HDR_OK   = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_BAD_TYPE = 3'd3,
    KIND_BAD_MODE = 3'd4
  } ota_pd_kind_e;

  typedef struct packed {
    ota_pd_kind_e       kind;
    logic [7:0]         payload_byte;
    logic               is_last;
    logic [15:0]        time_to_play;
    logic [7:0]         period_value;
    logic [3:0]         packet_type_out;
    logic [7:0]         channel_mode_raw;
    logic [2:0]         decoder_mode;
    logic [31:0]        session_ident;
    logic [PLEN_W-1:0]  payload_length;
  } ota_pd_result_t;

  typedef struct packed {
    logic                 in_payload;
    logic [HDR_CNT_W-1:0] header_count;
    logic [PLEN_W-1:0]    payload_remaining;
  } ota_pd_status_t;

  // Payload size per packet type; types at or above TYPE_COUNT are rejected
  function automatic logic [PLEN_W-1:0] type_payload_len(input logic [3:0] ptype);
    logic [PLEN_W-1:0] size;
    case (ptype)
      4'd0:    size = PLEN_W'(348);
      4'd1:    size = PLEN_W'(656);
      4'd2:    size = PLEN_W'(140);
      4'd3:    size = PLEN_W'(152);
      4'd4:    size = PLEN_W'(560);
      4'd5:    size = PLEN_W'(760);
      4'd6:    size = PLEN_W'(960);
      4'd7:    size = PLEN_W'(348);
      4'd8:    size = PLEN_W'(980);
      default: size = '0;
    endcase
    return size;
  endfunction

  // Map the raw channel mode byte to a decoder mode, none when unknown
  function automatic logic [2:0] map_mode(input logic [7:0] raw);
    logic [2:0] mode;
    case (raw)
      MODE_RAW_STD: mode = DEC_MODE_STD;
      MODE_RAW_HQ:  mode = DEC_MODE_HQ;
      MODE_RAW_A0:  mode = DEC_MODE_A0;
      MODE_RAW_C0:  mode = DEC_MODE_C0;
      default:      mode = DEC_MODE_NONE;
    endcase
    return mode;
  endfunction

endpackage

[hw/rtl/ota_pd_if.sv]
// ----------------------------------------------------------------------------
// Packet deframer stream interfaces
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface ota_pd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ota_pd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic        is_last;
  logic [15:0] time_to_play;
  logic [7:0]  period_value;
  logic [3:0]  packet_type_out;
  logic [7:0]  channel_mode_raw;
  logic [2:0]  decoder_mode;
  logic [31:0] session_ident;
  logic [9:0]  payload_length;

  modport source (
    output valid, output kind, output payload_byte, output is_last,
    output time_to_play, output period_value, output packet_type_out,
    output channel_mode_raw, output decoder_mode, output session_ident,
    output payload_length, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input is_last,
    input time_to_play, input period_value, input packet_type_out,
    input channel_mode_raw, input decoder_mode, input session_ident,
    input payload_length, output ready
  );
endinterface

[hw/rtl/ota_pd_decode.sv]
// ----------------------------------------------------------------------------
// Packet deframer decode stage
// Holds the framing state, collects header bytes, checks the header and
// counts payload bytes; produces one result per stepped byte.
// ----------------------------------------------------------------------------
module ota_pd_decode import ota_pd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  output ota_pd_result_t result_o,
  output ota_pd_status_t status_o
);

  logic                  in_payload_q, in_payload_d;
  logic [HDR_CNT_W-1:0]  header_count_q, header_count_d;
  logic [PLEN_W-1:0]     remaining_q, remaining_d;
  logic [HEADER_BYTES-2:0][7:0] hdr_q;

  logic              hdr_last;
  logic [7:0]        ptype;
  logic [7:0]        cmode;
  logic [2:0]        dmode;
  logic [PLEN_W-1:0] psize;

  assign hdr_last = (header_count_q == HDR_CNT_W'(HEADER_BYTES - 1));
  assign ptype    = hdr_q[3];
  assign cmode    = hdr_q[4];
  assign dmode    = map_mode(cmode);
  assign psize    = type_payload_len(ptype[3:0]);

  // Next state and result for the byte being stepped
  always_comb begin
    in_payload_d   = in_payload_q;
    header_count_d = header_count_q;
    remaining_d    = remaining_q;
    result_o       = '0;
    result_o.kind  = KIND_HDR_BYTE;

    if (in_payload_q) begin
      result_o.kind         = KIND_PAYLOAD;
      result_o.payload_byte = byte_i;
      if (remaining_q <= PLEN_W'(1)) begin
        result_o.is_last = 1'b1;
        remaining_d      = '0;
        in_payload_d     = 1'b0;
      end else begin
        remaining_d = remaining_q - PLEN_W'(1);
      end
    end else if (!hdr_last) begin
      header_count_d = header_count_q + HDR_CNT_W'(1);
    end else begin
      header_count_d = '0;
      if (ptype >= 8'(TYPE_COUNT)) begin
        result_o.kind = KIND_BAD_TYPE;
      end else if (dmode == DEC_MODE_NONE) begin
        result_o.kind = KIND_BAD_MODE;
      end else begin
        result_o.kind             = KIND_HDR_OK;
        result_o.time_to_play     = {hdr_q[1], hdr_q[0]};
        result_o.period_value     = hdr_q[2];
        result_o.packet_type_out  = ptype[3:0];
        result_o.channel_mode_raw = cmode;
        result_o.decoder_mode     = dmode;
        result_o.session_ident    = {byte_i, hdr_q[6], hdr_q[5], cmode};
        result_o.payload_length   = psize;
        remaining_d               = psize;
        in_payload_d              = (psize != '0);
      end
    end
  end

  // Advance framing state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      header_count_q <= '0;
      remaining_q    <= '0;
    end else if (step_i) begin
      in_payload_q   <= in_payload_d;
      header_count_q <= header_count_d;
      remaining_q    <= remaining_d;
    end
  end

  // Capture header bytes ahead of the final one
  always_ff @(posedge clk_i) begin
    if (step_i && !in_payload_q && !hdr_last) begin
      hdr_q[header_count_q] <= byte_i;
    end
  end

  assign status_o.in_payload        = in_payload_q;
  assign status_o.header_count      = header_count_q;
  assign status_o.payload_remaining = remaining_q;

endmodule

[hw/rtl/ota_packet_deframer.sv]
// ----------------------------------------------------------------------------
// Packet deframer top level
// Byte-stream packet deframer: header check, then payload pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in_i carries one stream byte per word. Every accepted byte yields
//   exactly one result word on res_out_o: header byte taken, header ok (with
//   timestamp, period, type, channel mode, decoder mode, session id and
//   payload length), payload byte (last one flagged), bad type or bad mode.
//   A rejected header is dropped and hunting restarts at the next byte.
//   An accepted byte is held in the input register, then decoded into the
//   result register when the decode stage steps; the result is offered from
//   the result register. Throughput: one byte per cycle while the receiver
//   does not stall, set by the single decode stage between the registers.
//   Reset clears the framing state to hunting a header with empty counts;
//   both stages come up empty.
//   When the receiver stalls, the result register holds its word, the input
//   register holds the next byte, and byte_in_i.ready drops once both are
//   full; a byte is still taken in the same cycle a result is drained.
// ----------------------------------------------------------------------------
`include "ota_packet_deframer_assert.svh"

module ota_packet_deframer import ota_pd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  ota_pd_byte_if.sink       byte_in_i,
  ota_pd_result_if.source   res_out_o
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           out_valid_q;
  ota_pd_result_t out_q;
  logic           out_free;
  logic           step;
  ota_pd_result_t result;
  ota_pd_status_t status;

  // Pipeline handshake: stage moves when the result register can take it
  assign out_free        = !out_valid_q || res_out_o.ready;
  assign step            = in_valid_q && out_free;
  assign byte_in_i.ready = !in_valid_q || step;

  ota_pd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result),
    .status_o (status)
  );

  // Input and result valid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_in_i.ready) begin
        in_valid_q <= byte_in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (byte_in_i.valid && byte_in_i.ready) begin
      in_byte_q <= byte_in_i.data_byte;
    end
    if (step) begin
      out_q <= result;
    end
  end

  // Drive the result channel
  assign res_out_o.valid            = out_valid_q;
  assign res_out_o.kind             = out_q.kind;
  assign res_out_o.payload_byte     = out_q.payload_byte;
  assign res_out_o.is_last          = out_q.is_last;
  assign res_out_o.time_to_play     = out_q.time_to_play;
  assign res_out_o.period_value     = out_q.period_value;
  assign res_out_o.packet_type_out  = out_q.packet_type_out;
  assign res_out_o.channel_mode_raw = out_q.channel_mode_raw;
  assign res_out_o.decoder_mode     = out_q.decoder_mode;
  assign res_out_o.session_ident    = out_q.session_ident;
  assign res_out_o.payload_length   = out_q.payload_length;

  `OTA_PD_ASSERT(a_payload_kind,
    step && status.in_payload |=> out_valid_q && out_q.kind == KIND_PAYLOAD,
    "payload byte not reported as payload")
  `OTA_PD_ASSERT(a_hdr_byte_kind,
    step && !status.in_payload && status.header_count != HDR_CNT_W'(HEADER_BYTES - 1)
      |=> out_q.kind == KIND_HDR_BYTE,
    "early header byte not reported as taken")
  `OTA_PD_ASSERT_ALWAYS(a_idle_counts,
    !status.in_payload |-> status.payload_remaining == '0,
    "payload count left over while hunting a header")
  `OTA_PD_ASSERT(a_payload_hdr_clear,
    status.in_payload |-> status.header_count == '0,
    "header count not cleared during payload")
  `OTA_PD_ASSERT(a_in_hold,
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q),
    "buffered byte lost while decode stage stalled")

endmodule
